// File: hw/rtl/drwc_pkg.sv
// Shared types, constants and register codes of the grid ray caster.
package drwc_pkg;

  // Default sizes of the map, the screen and the texture.
  localparam int DEF_MAP_COLS     = 32;
  localparam int DEF_MAP_ROWS     = 32;
  localparam int DEF_SCREEN_COLS  = 640;
  localparam int DEF_SCREEN_ROWS  = 480;
  localparam int DEF_TEXTURE_SIZE = 64;

  // Datapath widths.
  localparam int DIV_W  = 32;
  localparam int CAMX_W = 26;
  localparam int RAY_W  = 30;
  localparam int SIDE_W = 40;
  localparam int CELL_W = 8;
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 30;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X  = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y  = 3'd3;
  localparam logic [2:0] REG_PLANE_X     = 3'd4;
  localparam logic [2:0] REG_PLANE_Y     = 3'd5;

  // Command opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [9:0] screen_column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic       cell_solid;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        hit_side;
    logic [15:0] wall_distance;
    logic [11:0] line_height;
    logic [8:0]  draw_start;
    logic [8:0]  draw_end;
    logic [5:0]  texture_column;
    logic        ray_escaped;
  } res_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/drwc_stream_if.sv
// Valid/ready channel interfaces for commands and results.
interface drwc_cmd_if import drwc_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drwc_res_if import drwc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/drwc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module drwc_divider import drwc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DIV_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DIV_W:0]   rem;
  logic [DIV_W:0]   rem_next;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic             q_bit;

  // Shift in the next dividend bit and subtract where it fits.
  always_comb begin
    trial = {rem[DIV_W-1:0], quo[DIV_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = trial - {1'b0, dsr};
      q_bit    = 1'b1;
    end else begin
      rem_next = trial;
      q_bit    = 1'b0;
    end
  end

  // Iteration counter and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_W-2:0], q_bit};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign quotient  = quo;

endmodule

// File: hw/rtl/dda_raycast_wall_column_top.sv
// Top level of the grid ray caster: wall map, sequencer and datapath.
//
// Commands arrive on cmd and results leave on res, both valid/ready; a
// transfer happens on a clock edge with valid and ready high. A write
// command sets one map cell and gives no result; a cast command gives one
// result for its screen column. Camera registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle, which the block itself does not enforce. A cast runs under a
// sequencer around one shared 32-bit divider (one quotient bit a cycle)
// and one registered multiplier: four divisions, six multiplies, and a
// step state and a check state per grid step. A ray that escapes skips
// the last division and multiplies. The next command can be taken in the
// cycle after the result is loaded. A write command leaves the block idle.
// After reset the wall map is cleared, one cell a cycle, over all
// MAP_COLS * MAP_ROWS cells (1024 by default); cmd is not ready meanwhile.
// A finished result sits in an output register; the next command is taken
// while it waits, and a following cast holds at its end until res drains.
module dda_raycast_wall_column_top import drwc_pkg::*; #(
  parameter int MAP_COLS     = DEF_MAP_COLS,
  parameter int MAP_ROWS     = DEF_MAP_ROWS,
  parameter int SCREEN_COLS  = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS  = DEF_SCREEN_ROWS,
  parameter int TEXTURE_SIZE = DEF_TEXTURE_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  drwc_cmd_if.sink    cmd,
  drwc_res_if.source  res
);

  localparam int DEPTH      = MAP_COLS * MAP_ROWS;
  localparam int AW         = $clog2(DEPTH);
  localparam int STEP_LIMIT = MAP_COLS + MAP_ROWS + 4;
  localparam int SCW        = $clog2(STEP_LIMIT + 1);
  localparam int HALF       = SCREEN_ROWS / 2;

  typedef enum logic [16:0] {
    S_CLEAR    = 17'b00000000000000001,
    S_IDLE     = 17'b00000000000000010,
    S_DIV_CAMX = 17'b00000000000000100,
    S_MUL_RX   = 17'b00000000000001000,
    S_MUL_RY   = 17'b00000000000010000,
    S_DIV_DX   = 17'b00000000000100000,
    S_DIV_DY   = 17'b00000000001000000,
    S_MUL_SX   = 17'b00000000010000000,
    S_MUL_SY   = 17'b00000000100000000,
    S_SETUP    = 17'b00000001000000000,
    S_STEP     = 17'b00000010000000000,
    S_CHECK    = 17'b00000100000000000,
    S_DIV_LH   = 17'b00001000000000000,
    S_MUL_WP   = 17'b00010000000000000,
    S_MUL_TEX  = 17'b00100000000000000,
    S_FIN      = 17'b01000000000000000,
    S_FIN_WAIT = 17'b10000000000000000
  } state_t;

  state_t state;

  // Camera registers.
  logic        [15:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;

  // Cast working registers.
  logic [9:0]                col;
  logic signed [CAMX_W-1:0]  camx;
  logic signed [RAY_W-1:0]   rx, ry;
  logic [DIV_W-1:0]          dx, dy;
  logic [SIDE_W-1:0]         sx, sy, hit_dist;
  logic [CELL_W-1:0]         mx, my;
  logic                      side;
  logic                      escaped;
  logic [SCW-1:0]            step_cnt;
  logic [15:0]               wd;
  logic [11:0]               lh;
  logic                      div_pend;
  logic [AW-1:0]             clr_addr;

  // Shared multiplier.
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Shared divider.
  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_n, div_d, div_q;

  // Wall map.
  logic          mem [DEPTH];
  logic          mem_we, mem_wdata, rd_en, rdata;
  logic [AW-1:0] mem_waddr, raddr;

  // Output register.
  res_t res_data;
  logic res_valid;
  logic res_load;

  // Step decision and neighbour cell.
  logic              take_x, oob, cmd_xfer, cell_ok, is_div;
  logic [CELL_W-1:0] nmx, nmy, sgx, sgy;
  logic [10:0]       fxsel, fysel;
  logic [DIV_W-1:0]  abs_rx, abs_ry;
  logic [9:0]        wp_frac;
  logic [10:0]       lh_half;
  logic [11:0]       ds_w;
  logic [12:0]       de_w;
  logic [7:0]        tex_raw;
  logic [8:0]        tex_m;
  logic              mirror;

  assign cmd_xfer = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  assign sgx    = rx[RAY_W-1] ? {CELL_W{1'b1}} : CELL_W'(1);
  assign sgy    = ry[RAY_W-1] ? {CELL_W{1'b1}} : CELL_W'(1);
  assign take_x = sx < sy;
  assign nmx    = take_x ? mx + sgx : mx;
  assign nmy    = take_x ? my : my + sgy;
  assign oob    = nmx[CELL_W-1] || nmy[CELL_W-1] ||
                  (nmx >= CELL_W'(MAP_COLS)) || (nmy >= CELL_W'(MAP_ROWS));
  assign raddr  = AW'(nmx) * AW'(MAP_ROWS) + AW'(nmy);

  assign abs_rx = DIV_W'(rx[RAY_W-1] ? -rx : rx);
  assign abs_ry = DIV_W'(ry[RAY_W-1] ? -ry : ry);
  assign fxsel  = rx[RAY_W-1] ? {1'b0, pos_x[9:0]} : 11'd1024 - {1'b0, pos_x[9:0]};
  assign fysel  = ry[RAY_W-1] ? {1'b0, pos_y[9:0]} : 11'd1024 - {1'b0, pos_y[9:0]};

  // Fractional wall point from the product of distance and ray component.
  assign wp_frac = (side ? pos_x[9:0] : pos_y[9:0]) + mul_p[21:12];

  // Draw span and texture column of the final result.
  assign lh_half = lh[11:1];
  assign ds_w    = (12'(lh_half) > 12'(HALF)) ? 12'd0 : 12'(HALF) - 12'(lh_half);
  assign de_w    = (13'(HALF) + 13'(lh_half) >= 13'(SCREEN_ROWS)) ?
                   13'(SCREEN_ROWS - 1) : 13'(HALF) + 13'(lh_half);
  assign tex_raw = mul_p[17:10];
  assign mirror  = (!side && !rx[RAY_W-1] && (rx != '0)) || (side && ry[RAY_W-1]);
  assign tex_m   = mirror ? 9'(TEXTURE_SIZE - 1) - {1'b0, tex_raw} : {1'b0, tex_raw};

  // Operand selection for the shared divider.
  assign is_div = (state == S_DIV_CAMX) || (state == S_DIV_DX) ||
                  (state == S_DIV_DY) || (state == S_DIV_LH);
  assign div_ctrl.start = is_div && !div_pend;

  always_comb begin
    div_n = '0;
    div_d = '0;
    unique case (state)
      S_DIV_CAMX: begin
        div_n = DIV_W'(col) << 15;
        div_d = DIV_W'(SCREEN_COLS);
      end
      S_DIV_DX: begin
        div_n = DIV_W'(1) << 30;
        div_d = abs_rx;
      end
      S_DIV_DY: begin
        div_n = DIV_W'(1) << 30;
        div_d = abs_ry;
      end
      S_DIV_LH: begin
        div_n = DIV_W'(SCREEN_ROWS * 256);
        div_d = DIV_W'(wd);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  drwc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_n),
    .divisor  (div_d),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_MUL_RX: begin
        mul_a = MUL_A_W'(camx);
        mul_b = MUL_B_W'(plane_x);
      end
      S_MUL_RY: begin
        mul_a = MUL_A_W'(camx);
        mul_b = MUL_B_W'(plane_y);
      end
      S_MUL_SX: begin
        mul_a = $signed({2'b00, dx});
        mul_b = $signed({19'd0, fxsel});
      end
      S_MUL_SY: begin
        mul_a = $signed({2'b00, dy});
        mul_b = $signed({19'd0, fysel});
      end
      S_MUL_WP: begin
        mul_a = $signed({18'd0, wd});
        mul_b = side ? MUL_B_W'(rx) : MUL_B_W'(ry);
      end
      S_MUL_TEX: begin
        mul_a = $signed({24'd0, wp_frac});
        mul_b = MUL_B_W'(TEXTURE_SIZE);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_p <= mul_a * mul_b;
    end
  end

  // Wall map write port: clearing pass or cell write.
  assign cell_ok   = (7'(cmd.data.cell_x) < 7'(MAP_COLS)) &&
                     (7'(cmd.data.cell_y) < 7'(MAP_ROWS));
  assign mem_we    = (state == S_CLEAR) ||
                     (cmd_xfer && (cmd.data.opcode == OP_WRITE) && cell_ok);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr :
                     AW'(cmd.data.cell_x) * AW'(MAP_ROWS) + AW'(cmd.data.cell_y);
  assign mem_wdata = (state == S_CLEAR) ? 1'b0 : cmd.data.cell_solid;
  assign rd_en     = (state == S_STEP) && !oob;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Camera register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= 16'd10240;
      pos_y   <= 16'd4096;
      dir_x   <= -16'sd16384;
      dir_y   <= 16'sd0;
      plane_x <= 16'sd0;
      plane_y <= 16'sd10813;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_POS_X:  pos_x   <= cfg_data;
        REG_CAM_POS_Y:  pos_y   <= cfg_data;
        REG_VIEW_DIR_X: dir_x   <= $signed(cfg_data);
        REG_VIEW_DIR_Y: dir_y   <= $signed(cfg_data);
        REG_PLANE_X:    plane_x <= $signed(cfg_data);
        REG_PLANE_Y:    plane_y <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // A finished cast loads the output register when it is free or draining.
  assign res_load = ((state == S_FIN) || (state == S_FIN_WAIT)) &&
                    (!res_valid || res.ready);

  // Sequencer and cast datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      div_pend  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (div_ctrl.start) begin
        div_pend <= 1'b1;
      end
      if (div_stat.done) begin
        div_pend <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_xfer && (cmd.data.opcode == OP_CAST)) begin
            col   <= cmd.data.screen_column;
            state <= S_DIV_CAMX;
          end
        end
        S_DIV_CAMX: begin
          if (div_stat.done) begin
            camx  <= CAMX_W'(div_q) - CAMX_W'(16384);
            state <= S_MUL_RX;
          end
        end
        S_MUL_RX: state <= S_MUL_RY;
        S_MUL_RY: begin
          rx    <= RAY_W'(dir_x) + RAY_W'(mul_p >>> 14);
          state <= S_DIV_DX;
        end
        S_DIV_DX: begin
          ry <= RAY_W'(dir_y) + RAY_W'(mul_p >>> 14);
          if (div_stat.done) begin
            dx    <= (rx == '0) ? {DIV_W{1'b1}} : div_q;
            state <= S_DIV_DY;
          end
        end
        S_DIV_DY: begin
          if (div_stat.done) begin
            dy    <= (ry == '0) ? {DIV_W{1'b1}} : div_q;
            state <= S_MUL_SX;
          end
        end
        S_MUL_SX: state <= S_MUL_SY;
        S_MUL_SY: begin
          sx    <= mul_p[SIDE_W+9:10];
          state <= S_SETUP;
        end
        S_SETUP: begin
          sy       <= mul_p[SIDE_W+9:10];
          mx       <= CELL_W'(pos_x[15:10]);
          my       <= CELL_W'(pos_y[15:10]);
          step_cnt <= '0;
          if ((7'(pos_x[15:10]) >= 7'(MAP_COLS)) || (7'(pos_y[15:10]) >= 7'(MAP_ROWS))) begin
            escaped <= 1'b1;
            state   <= S_FIN;
          end else begin
            escaped <= 1'b0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          mx <= nmx;
          my <= nmy;
          if (take_x) begin
            hit_dist <= sx;
            sx       <= sx + SIDE_W'(dx);
            side     <= 1'b0;
          end else begin
            hit_dist <= sy;
            sy       <= sy + SIDE_W'(dy);
            side     <= 1'b1;
          end
          if (oob) begin
            escaped <= 1'b1;
            state   <= S_FIN;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          wd <= (hit_dist[SIDE_W-1:8] > 32'd65535) ? 16'hFFFF : hit_dist[23:8];
          if (rdata) begin
            state <= S_DIV_LH;
          end else if (step_cnt == SCW'(STEP_LIMIT - 1)) begin
            escaped <= 1'b1;
            state   <= S_FIN;
          end else begin
            step_cnt <= step_cnt + 1'b1;
            state    <= S_STEP;
          end
        end
        S_DIV_LH: begin
          if (div_stat.done) begin
            lh    <= ((wd == '0) || (div_q > DIV_W'(4095))) ? 12'hFFF : div_q[11:0];
            state <= S_MUL_WP;
          end
        end
        S_MUL_WP:  state <= S_MUL_TEX;
        S_MUL_TEX: state <= S_FIN;
        S_FIN, S_FIN_WAIT: begin
          if (res_load) begin
            res_data.column_out    <= col;
            res_data.ray_escaped   <= escaped;
            if (escaped) begin
              res_data.hit_side       <= 1'b0;
              res_data.wall_distance  <= '0;
              res_data.line_height    <= '0;
              res_data.draw_start     <= '0;
              res_data.draw_end       <= '0;
              res_data.texture_column <= '0;
            end else begin
              res_data.hit_side       <= side;
              res_data.wall_distance  <= wd;
              res_data.line_height    <= lh;
              res_data.draw_start     <= ds_w[8:0];
              res_data.draw_end       <= de_w[8:0];
              res_data.texture_column <= tex_m[5:0];
            end
            state <= S_IDLE;
          end else begin
            state <= S_FIN_WAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

`ifndef SYNTHESIS
  // No command is taken while the map is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !cmd.ready)
    else $error("command accepted during map clear");

  // The divider finishes only while the sequencer waits on it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> is_div)
    else $error("divider result outside a divide state");

  // The grid walk never runs past its step limit.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (step_cnt < SCW'(STEP_LIMIT)))
    else $error("grid walk past step limit");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready && (state == S_FIN_WAIT)) |=> (state == S_FIN_WAIT || res_valid))
    else $error("result overwritten while waiting");
`endif

endmodule
